@@ rtl/core/pps_pkg.sv @@
// Shared types and codes for the preemptive priority scheduler.
// Depends on nothing.
package pps_pkg;

	typedef enum logic [1:0] {
		KIND_ACCEPT = 2'd0,
		KIND_REJECT = 2'd1,
		KIND_IDLE   = 2'd2,
		KIND_RAN    = 2'd3
	} kind_t;

	localparam logic CMD_ARRIVE = 1'b0;
	localparam logic CMD_TICK   = 1'b1;

	// One heap entry
	typedef struct packed {
		logic [7:0]  prio;
		logic [7:0]  pid;
		logic [15:0] remaining;
		logic [15:0] burst;
		logic [31:0] arrival;
		logic        started;
	} entry_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PUT,
		ST_UP_RD,
		ST_UP_CMP,
		ST_ROOT_RD,
		ST_LAST_RD,
		ST_DN_RD,
		ST_DN_CMP,
		ST_REINS,
		ST_OUT
	} state_t;

	// Controller commands to the datapath
	typedef struct packed {
		logic capture_in;   // latch input word
		logic put_new;      // write new entry at count, count++
		logic up_read;      // read parent of pos
		logic up_step;      // compare/swap with parent
		logic root_read;    // read root
		logic root_take;    // latch root, count--, read last
		logic last_place;   // place last at 0, start sift-down
		logic dn_read;      // read children
		logic dn_step;      // compare/swap with best child
		logic reins;        // prepare reinsert entry
		logic idle_tick;    // empty tick
		logic out_load;     // present result
	} cmd_t;

	typedef struct packed {
		logic cmd;
		logic full;
		logic empty;
		logic up_done;
		logic dn_done;
		logic requeue;
		logic out_busy;
	} sts_t;

endpackage

@@ rtl/core/pps_if.sv @@
// Valid/ready channel interface for scheduler words.
// Depends on nothing.
interface pps_in_if;
	logic        valid;
	logic        ready;
	logic        command;
	logic [7:0]  process_id;
	logic [7:0]  prio_level;
	logic [15:0] burst_length;
	modport source (output valid, command, process_id, prio_level, burst_length, input ready);
	modport sink   (input valid, command, process_id, prio_level, burst_length, output ready);
endinterface

interface pps_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [7:0]  run_id;
	logic        first_run;
	logic [31:0] response_time;
	logic        finished;
	logic [31:0] finish_time;
	logic [31:0] turnaround_time;
	logic [31:0] waiting_time;
	modport source (output valid, kind, run_id, first_run, response_time, finished,
		finish_time, turnaround_time, waiting_time, input ready);
	modport sink   (input valid, kind, run_id, first_run, response_time, finished,
		finish_time, turnaround_time, waiting_time, output ready);
endinterface

@@ rtl/core/preemptive_priority_scheduler.sv @@
// Channel    Dir  Fields
// in_ch      in   command, process_id, prio_level, burst_length
// out_ch     out  kind, run_id, first_run, response_time, finished, finish_time,
//                 turnaround_time, waiting_time
// One word at a time. An arrive writes the new entry and sifts it up past its parents;
// a tick takes the root, moves the last entry to the root, sifts it down and, when
// the process is requeued, sifts it up again. Reads are registered.
// Reset clears count, time and handshake. A waiting result does not block the
// next word; a new result waits in the output state until the last one is taken.
// Depends on pps_pkg, pps_if, pps_ctrl, pps_dpath.
module preemptive_priority_scheduler import pps_pkg::*; #(
	parameter int HEAP_DEPTH = 64
) (
	input logic        clk,
	input logic        arst_n,
	pps_in_if.sink     in_ch,
	pps_out_if.source  out_ch
);

	cmd_t cmd;
	sts_t sts;

	pps_ctrl u_ctrl (
		.clk, .arst_n, .in_valid(in_ch.valid), .in_ready(in_ch.ready), .sts, .cmd
	);

	pps_dpath #(.HEAP_DEPTH(HEAP_DEPTH)) u_dpath (
		.clk, .arst_n, .cmd, .sts,
		.i_command(in_ch.command), .i_pid(in_ch.process_id),
		.i_prio(in_ch.prio_level), .i_burst(in_ch.burst_length),
		.o_valid(out_ch.valid), .o_ready(out_ch.ready), .o_kind(out_ch.kind),
		.o_run_id(out_ch.run_id), .o_first(out_ch.first_run),
		.o_resp(out_ch.response_time), .o_fin(out_ch.finished),
		.o_fin_time(out_ch.finish_time), .o_turn(out_ch.turnaround_time),
		.o_wait(out_ch.waiting_time)
	);

endmodule

@@ rtl/core/pps_ctrl.sv @@
// Controller state machine of the scheduler.
// Depends on pps_pkg.
module pps_ctrl import pps_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_nx;
	end

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: if (in_valid) state_nx = ST_PUT;
			ST_PUT: begin
				if (sts.cmd == CMD_ARRIVE) state_nx = sts.full ? ST_OUT : ST_UP_RD;
				else state_nx = sts.empty ? ST_OUT : ST_ROOT_RD;
			end
			ST_UP_RD:   state_nx = sts.up_done ? ST_OUT : ST_UP_CMP;
			ST_UP_CMP:  state_nx = ST_UP_RD;
			ST_ROOT_RD: state_nx = ST_LAST_RD;
			ST_LAST_RD: state_nx = ST_DN_RD;
			ST_DN_RD:   state_nx = sts.dn_done ? ST_REINS : ST_DN_CMP;
			ST_DN_CMP:  state_nx = ST_DN_RD;
			ST_REINS:   state_nx = sts.requeue ? ST_UP_RD : ST_OUT;
			ST_OUT:     state_nx = sts.out_busy ? ST_OUT : ST_IDLE;
			default:    state_nx = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.capture_in = in_valid;
			end
			ST_PUT: begin
				if (sts.cmd == CMD_ARRIVE) cmd.put_new = !sts.full;
				else if (sts.empty) cmd.idle_tick = 1'b1;
				else cmd.root_read = 1'b1;
			end
			ST_UP_RD:   cmd.up_read = 1'b1;
			ST_UP_CMP:  cmd.up_step = 1'b1;
			ST_ROOT_RD: cmd.root_take = 1'b1;
			ST_LAST_RD: cmd.last_place = 1'b1;
			ST_DN_RD:   cmd.dn_read = 1'b1;
			ST_DN_CMP:  cmd.dn_step = 1'b1;
			ST_REINS:   cmd.reins = 1'b1;
			ST_OUT:     cmd.out_load = !sts.out_busy;
			default: ;
		endcase
	end

endmodule

@@ rtl/core/pps_dpath.sv @@
// Heap memory, time counter and result register of the scheduler.
// Depends on pps_pkg.
module pps_dpath import pps_pkg::*; #(
	parameter int HEAP_DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output sts_t        sts,
	input  logic        i_command,
	input  logic [7:0]  i_pid,
	input  logic [7:0]  i_prio,
	input  logic [15:0] i_burst,
	output logic        o_valid,
	input  logic        o_ready,
	output logic [1:0]  o_kind,
	output logic [7:0]  o_run_id,
	output logic        o_first,
	output logic [31:0] o_resp,
	output logic        o_fin,
	output logic [31:0] o_fin_time,
	output logic [31:0] o_turn,
	output logic [31:0] o_wait
);

	localparam int AW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
	localparam int CW = $clog2(HEAP_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(HEAP_DEPTH);

	entry_t mem [HEAP_DEPTH];

	logic [CW-1:0] count_q;
	logic [31:0]   time_q;
	logic          cmd_q;
	logic [7:0]    pid_q, prio_q;
	logic [15:0]   burst_q;
	logic [AW-1:0] pos_q;      // node being sifted
	entry_t        node_q;     // entry held at pos
	entry_t        rd_a_q, rd_b_q; // parent / left, right
	entry_t        root_q;     // extracted entry
	logic          first_q, fin_q;
	logic [1:0]    kind_q;

	// derived
	logic [AW-1:0] parent;
	logic [CW:0]   left_w, right_w;
	logic          l_ok, r_ok;
	logic [15:0]   rem_dec;
	logic [31:0]   fin_time;
	assign parent  = (pos_q - AW'(1)) >> 1;
	assign left_w  = (CW+1)'({pos_q, 1'b1});
	assign right_w = left_w + (CW+1)'(1);
	assign l_ok    = left_w < (CW+1)'(count_q);
	assign r_ok    = right_w < (CW+1)'(count_q);
	assign rem_dec = (root_q.remaining != 16'd0) ? root_q.remaining - 16'd1 : 16'd0;
	assign fin_time = time_q + 32'd1;

	// sift-down choice with left first, strict compare
	logic          l_win, r_win;
	logic [7:0]    best_p;
	always_comb begin
		l_win = l_ok && (rd_a_q.prio < node_q.prio);
		best_p = l_win ? rd_a_q.prio : node_q.prio;
		r_win = r_ok && (rd_b_q.prio < best_p);
	end

	assign sts.cmd      = cmd_q;
	assign sts.full     = count_q >= DEPTH_C;
	assign sts.empty    = count_q == '0;
	assign sts.up_done  = pos_q == '0;
	assign sts.dn_done  = !l_ok;
	assign sts.requeue  = rem_dec != 16'd0;
	assign sts.out_busy = o_valid && !o_ready;

	// memory port: registered reads
	always_ff @(posedge clk) begin
		if (cmd.put_new)
			mem[count_q[AW-1:0]] <= '{prio: prio_q, pid: pid_q, remaining: burst_q,
				burst: burst_q, arrival: time_q, started: 1'b0};
		if (cmd.up_read) rd_a_q <= mem[parent];
		if (cmd.up_step && rd_a_q.prio > node_q.prio) begin
			mem[parent] <= node_q;
			mem[pos_q]  <= rd_a_q;
		end
		if (cmd.root_read) rd_a_q <= mem[0];
		if (cmd.root_take) rd_b_q <= mem[AW'(count_q - CW'(1))];
		if (cmd.last_place) mem[0] <= rd_b_q;
		if (cmd.dn_read) begin
			rd_a_q <= mem[left_w[AW-1:0]];
			rd_b_q <= mem[r_ok ? right_w[AW-1:0] : left_w[AW-1:0]];
		end
		if (cmd.dn_step && (l_win || r_win)) begin
			mem[pos_q] <= r_win ? rd_b_q : rd_a_q;
			mem[r_win ? right_w[AW-1:0] : left_w[AW-1:0]] <= node_q;
		end
		if (cmd.reins)
			mem[count_q[AW-1:0]] <= '{prio: root_q.prio, pid: root_q.pid,
				remaining: rem_dec, burst: root_q.burst, arrival: root_q.arrival,
				started: 1'b1};
	end

	// position, node and captured input
	always_ff @(posedge clk) begin
		if (cmd.capture_in) begin
			cmd_q <= i_command; pid_q <= i_pid; prio_q <= i_prio; burst_q <= i_burst;
		end
		if (cmd.put_new) begin
			pos_q <= count_q[AW-1:0];
			node_q <= '{prio: prio_q, pid: pid_q, remaining: burst_q, burst: burst_q,
				arrival: time_q, started: 1'b0};
		end
		if (cmd.up_step) begin
			if (rd_a_q.prio > node_q.prio) pos_q <= parent;
			else pos_q <= '0;
		end
		if (cmd.root_take) root_q <= rd_a_q;
		if (cmd.last_place) begin
			pos_q <= '0;
			node_q <= rd_b_q;
		end
		if (cmd.dn_step) begin
			if (r_win) pos_q <= right_w[AW-1:0];
			else if (l_win) pos_q <= left_w[AW-1:0];
			else pos_q <= {AW{1'b1}};
		end
		if (cmd.reins) begin
			pos_q <= count_q[AW-1:0];
			node_q <= '{prio: root_q.prio, pid: root_q.pid, remaining: rem_dec,
				burst: root_q.burst, arrival: root_q.arrival, started: 1'b1};
		end
	end

	// count and result kind
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			kind_q  <= KIND_ACCEPT;
		end else begin
			if (cmd.put_new || (cmd.reins && rem_dec != 16'd0)) count_q <= count_q + CW'(1);
			if (cmd.root_take) count_q <= count_q - CW'(1);
			if (cmd.put_new) kind_q <= KIND_ACCEPT;
			else if (cmd.idle_tick) kind_q <= KIND_IDLE;
			else if (cmd.root_read) kind_q <= KIND_RAN;
			else if (cmd.capture_in) kind_q <= KIND_REJECT;
		end
	end

	// result fields
	always_ff @(posedge clk) begin
		if (cmd.reins) begin
			first_q <= !root_q.started;
			fin_q   <= rem_dec == 16'd0;
		end
		if (cmd.out_load) begin
			o_kind     <= kind_q;
			o_run_id   <= '0; o_first <= 1'b0; o_resp <= '0; o_fin <= 1'b0;
			o_fin_time <= '0; o_turn <= '0; o_wait <= '0;
			if (kind_q == KIND_RAN) begin
				o_run_id <= root_q.pid;
				o_first  <= first_q;
				if (first_q) o_resp <= time_q - root_q.arrival;
				o_fin <= fin_q;
				if (fin_q) begin
					o_fin_time <= fin_time;
					o_turn <= fin_time - root_q.arrival;
					o_wait <= fin_time - root_q.arrival - {16'd0, root_q.burst};
				end
			end
		end
	end

	// time advances after a tick result is formed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) o_valid <= 1'b0;
		else if (cmd.out_load) o_valid <= 1'b1;
		else if (o_ready) o_valid <= 1'b0;
	end
	logic tick_done;
	assign tick_done = cmd.out_load && cmd_q == CMD_TICK;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) time_q <= '0;
		else if (tick_done) time_q <= fin_time;
	end

	// waiting result word holds steady
	assert property (@(posedge clk) disable iff (!arst_n)
		o_valid && !o_ready |=> o_valid && $stable(o_kind) && $stable(o_run_id)
			&& $stable(o_first) && $stable(o_resp) && $stable(o_fin)
			&& $stable(o_fin_time) && $stable(o_turn) && $stable(o_wait));

	// heap never holds more than its depth
	assert property (@(posedge clk) disable iff (!arst_n) count_q <= DEPTH_C);

	// new result only into a free output register
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !(o_valid && !o_ready));

endmodule

@@ verif/tb_top.sv @@
// Testbench for the preemptive priority scheduler: directed and random arrive/tick words
// checked against an in-bench heap scheduler model through a scoreboard class.
// Depends on pps_pkg, pps_if and the scheduler RTL.
module tb_top;
	import pps_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = 64;
	localparam longint CYCLE_LIMIT = 64'd2000000;

	typedef struct {
		kind_t       kind;
		logic [7:0]  run_id;
		logic        first_run;
		logic [31:0] response_time;
		logic        finished;
		logic [31:0] finish_time;
		logic [31:0] turnaround_time;
		logic [31:0] waiting_time;
	} sched_result_t;

	// Scheduler model plus queue of pending results
	class sched_scoreboard;
		entry_t        slots[DEPTH];
		int            count;
		logic [31:0]   now;
		sched_result_t pending[$];
		int            errors;

		function void clear();
			count = 0;
			now = 0;
			pending.delete();
			errors = 0;
		endfunction

		function void swap(int a, int b);
			entry_t t;
			t = slots[a];
			slots[a] = slots[b];
			slots[b] = t;
		endfunction

		function void insert(entry_t e);
			int pos;
			int par;
			pos = count;
			slots[pos] = e;
			count++;
			while (pos != 0) begin
				par = (pos - 1) / 2;
				if (slots[par].prio > slots[pos].prio) begin
					swap(par, pos);
					pos = par;
				end else begin
					break;
				end
			end
		endfunction

		function void sift(int pos);
			int best;
			forever begin
				best = pos;
				if (2 * pos + 1 < count && slots[2 * pos + 1].prio < slots[best].prio)
					best = 2 * pos + 1;
				if (2 * pos + 2 < count && slots[2 * pos + 2].prio < slots[best].prio)
					best = 2 * pos + 2;
				if (best == pos)
					break;
				swap(best, pos);
				pos = best;
			end
		endfunction

		// Note an accepted input word and queue its result
		function void note_word(logic cmd, logic [7:0] pid, logic [7:0] prio,
			logic [15:0] burst);
			sched_result_t r;
			entry_t e;
			logic [31:0] fin;
			logic [31:0] turn;
			r = '{KIND_ACCEPT, 0, 0, 0, 0, 0, 0, 0};
			if (cmd == CMD_ARRIVE) begin
				if (count >= DEPTH) begin
					r.kind = KIND_REJECT;
				end else begin
					e = '{prio, pid, burst, burst, now, 1'b0};
					insert(e);
				end
			end else if (count == 0) begin
				r.kind = KIND_IDLE;
				now = now + 1;
			end else begin
				e = slots[0];
				fin = now + 1;
				count--;
				if (count >= 1) begin
					swap(0, count);
					sift(0);
				end
				r.kind = KIND_RAN;
				r.run_id = e.pid;
				if (!e.started) begin
					r.first_run = 1;
					r.response_time = now - e.arrival;
				end
				if (e.remaining > 0)
					e.remaining = e.remaining - 1;
				if (e.remaining > 0) begin
					e.started = 1;
					insert(e);
				end else begin
					turn = fin - e.arrival;
					r.finished = 1;
					r.finish_time = fin;
					r.turnaround_time = turn;
					r.waiting_time = turn - 32'(e.burst);
				end
				now = fin;
			end
			pending = {pending, r};
		endfunction

		function void cmp(string name, logic [31:0] exp_v, logic [31:0] act_v);
			if (exp_v !== act_v) begin
				$error("%s: expected %0h, actual %0h", name, exp_v, act_v);
				errors++;
			end
		endfunction

		// Check one accepted result word against the oldest expectation
		function void check_word(sched_result_t a);
			sched_result_t x;
			if (pending.size() == 0) begin
				$error("kind: expected none, actual %0d", a.kind);
				errors++;
				return;
			end
			x = pending.pop_front();
			cmp("kind", 32'(x.kind), 32'(a.kind));
			cmp("run_id", 32'(x.run_id), 32'(a.run_id));
			cmp("first_run", 32'(x.first_run), 32'(a.first_run));
			cmp("response_time", x.response_time, a.response_time);
			cmp("finished", 32'(x.finished), 32'(a.finished));
			cmp("finish_time", x.finish_time, a.finish_time);
			cmp("turnaround_time", x.turnaround_time, a.turnaround_time);
			cmp("waiting_time", x.waiting_time, a.waiting_time);
		endfunction
	endclass

	logic clk;
	logic arst_n;
	longint cycles;
	bit calm;    // no idling on either side while set
	sched_scoreboard sb;

	pps_in_if  in_ch();
	pps_out_if out_ch();

	preemptive_priority_scheduler #(.HEAP_DEPTH(DEPTH)) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch.sink),
		.out_ch(out_ch.source)
	);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	initial begin
		sb = new();
		sb.clear();
		calm = 0;
		arst_n = 0;
		in_ch.valid = 0;
		in_ch.command = 0;
		in_ch.process_id = 0;
		in_ch.prio_level = 0;
		in_ch.burst_length = 0;
		out_ch.ready = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1;
	end

	// Cycle limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("preemptive_priority_scheduler test failed");
			$finish;
		end
	end
	initial cycles = 0;

	// Result sink with random stalls
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready)
				sb.check_word('{kind_t'(out_ch.kind), out_ch.run_id, out_ch.first_run,
					out_ch.response_time, out_ch.finished, out_ch.finish_time,
					out_ch.turnaround_time, out_ch.waiting_time});
			out_ch.ready <= calm || ($urandom_range(99) >= 21);
		end
	end

	// Drive one word, with a random gap first, and wait for acceptance
	task automatic send_word(logic cmd, logic [7:0] pid, logic [7:0] prio,
		logic [15:0] burst);
		bit gap;
		gap = !calm && ($urandom_range(99) < 21);
		if (gap)
			in_ch.valid <= 0;
		while (gap) begin
			@(posedge clk);
			gap = !calm && ($urandom_range(99) < 21);
		end
		in_ch.valid <= 1;
		in_ch.command <= cmd;
		in_ch.process_id <= pid;
		in_ch.prio_level <= prio;
		in_ch.burst_length <= burst;
		@(posedge clk iff in_ch.ready);
		sb.note_word(cmd, pid, prio, burst);
	endtask

	task automatic drain();
		in_ch.valid <= 0;
		while (sb.pending.size() != 0)
			@(posedge clk);
	endtask

	// Random word: ticks and arrivals, the arrivals mostly with short bursts
	task automatic send_random();
		int sel;
		logic [15:0] b;
		sel = $urandom_range(99);
		if ($urandom_range(19) == 0)
			b = 16'($urandom);
		else
			b = 16'($urandom_range(4));
		if (sel < 45)
			send_word(CMD_ARRIVE, 8'($urandom), 8'($urandom_range(255)), b);
		else
			send_word(CMD_TICK, 8'($urandom), 8'($urandom), 16'($urandom));
	endtask

	initial begin
		int i;
		@(posedge arst_n);
		@(posedge clk);
		// Directed: idle tick on empty heap, zero burst, field extremes, ties
		send_word(CMD_TICK, 8'h00, 8'h00, 16'h0000);
		send_word(CMD_ARRIVE, 8'hFF, 8'hFF, 16'h0000);
		send_word(CMD_TICK, 8'h00, 8'h00, 16'h0000);
		send_word(CMD_ARRIVE, 8'h00, 8'h00, 16'hFFFF);
		send_word(CMD_ARRIVE, 8'h11, 8'h05, 16'h0002);
		send_word(CMD_ARRIVE, 8'h22, 8'h05, 16'h0001);
		send_word(CMD_ARRIVE, 8'h33, 8'h05, 16'h0003);
		for (i = 0; i < 6; i++)
			send_word(CMD_TICK, 8'hFF, 8'hFF, 16'hFFFF);
		// Pause until every result is in
		drain();
		// Fill the heap past full to hit rejection, then send ticks to run it down
		for (i = 0; i < DEPTH + 3; i++)
			send_word(CMD_ARRIVE, 8'(i), 8'($urandom_range(3)), 16'($urandom_range(2)));
		drain();
		for (i = 0; i < 2 * DEPTH + 8; i++)
			send_word(CMD_TICK, 8'h00, 8'h00, 16'h0000);
		// Random part, with a calm stretch in the middle
		for (i = 0; i < 600; i++) begin
			calm = (i >= 250 && i < 350);
			send_random();
		end
		calm = 0;
		drain();
		repeat (200) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("preemptive_priority_scheduler test passed");
		else
			$display("preemptive_priority_scheduler test failed");
		$finish;
	end

endmodule
